>>> rtl/core/jtsm_pkg.sv
// Shared types and codes for the JTAG TAP shift master.
// No dependencies; imported by every module of the block.
package jtsm_pkg;

    // Operation codes on the request port
    typedef enum logic [2:0] {
        OP_RESET = 3'd0,
        OP_SETIR = 3'd1,
        OP_DETIR = 3'd2,
        OP_DATA  = 3'd3,
        OP_TICK  = 3'd4
    } jtsm_op_t;

    // Command kinds held by the sequencer
    typedef enum logic [1:0] {
        KIND_RESET = 2'd0,
        KIND_SETIR = 2'd1,
        KIND_DETIR = 2'd2,
        KIND_DATA  = 2'd3
    } jtsm_kind_t;

    // Sequencer phases, one-hot
    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_RESET = 5'b00010,
        PH_MOVE  = 5'b00100,
        PH_SHIFT = 5'b01000,
        PH_EXIT  = 5'b10000
    } jtsm_phase_t;

    localparam int WORD_W      = 32;
    localparam int IR_LEN_W    = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [IR_LEN_W-1:0] IR_LEN_RESET = IR_LEN_W'(5);
    localparam logic [IR_LEN_W-1:0] IR_LEN_MAX   = IR_LEN_W'(32);
    localparam logic [WORD_W-1:0]   LAST_IR_RESET = 32'hFFFF_FFFF;

    // Classified request passed from front end to sequencer
    typedef struct packed {
        logic              is_tick;
        jtsm_kind_t        kind;
        logic [WORD_W-1:0] word;
        logic              tdo;
    } jtsm_item_t;

    // One TCK pulse result
    typedef struct packed {
        logic              tms;
        logic              tdi;
        logic              done;
        logic [WORD_W-1:0] cap;
    } jtsm_result_t;

endpackage

>>> rtl/core/jtsm_front.sv
// Front end: decodes the operation code of each request and drops unused codes.
// Depends on jtsm_pkg.
module jtsm_front
    import jtsm_pkg::*;
(
    input  logic [2:0]        operation,
    input  logic [WORD_W-1:0] shift_word,
    input  logic              tdo_sample,
    output logic              keep,
    output jtsm_item_t        item
);

    // Classify the operation into a tick or a command kind
    always_comb
    begin
        item.word    = shift_word;
        item.tdo     = tdo_sample;
        item.is_tick = 1'b0;
        item.kind    = KIND_RESET;
        keep         = 1'b1;
        unique case (operation)
            OP_RESET: item.kind = KIND_RESET;
            OP_SETIR: item.kind = KIND_SETIR;
            OP_DETIR: item.kind = KIND_DETIR;
            OP_DATA:  item.kind = KIND_DATA;
            OP_TICK:  item.is_tick = 1'b1;
            default:  keep = 1'b0;
        endcase
    end

endmodule

>>> rtl/core/jtsm_queue.sv
// Short request queue between the front end and the sequencer.
// Depends on jtsm_pkg.
module jtsm_queue
    import jtsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  jtsm_item_t wr_item,
    output logic       full,
    input  logic       rd_en,
    output logic       rd_valid,
    output jtsm_item_t rd_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    jtsm_item_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

>>> rtl/core/jtsm_back.sv
// Back end: TAP sequencer that turns queued requests into TCK pulses,
// plus the result register. Depends on jtsm_pkg.
module jtsm_back
    import jtsm_pkg::*;
#(
    parameter int DATA_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [IR_LEN_W-1:0] ir_length,
    input  logic                q_valid,
    input  jtsm_item_t          q_item,
    output logic                q_pop,
    input  logic                pop,
    output logic                empty,
    output jtsm_result_t        result
);

    localparam int SHIFT_W = (DATA_BITS > WORD_W) ? DATA_BITS : WORD_W;
    localparam int CNT_W   = $clog2(SHIFT_W + 1);

    jtsm_phase_t         phase_reg, phase_next;
    jtsm_kind_t          kind_reg, kind_next;
    logic                tap_idle_reg, tap_idle_next;
    logic [WORD_W-1:0]   last_ir_reg, last_ir_next;
    logic [SHIFT_W-1:0]  shift_reg, shift_next;
    logic [WORD_W-1:0]   cap_reg, cap_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    jtsm_result_t        out_res_reg, out_res_next;

    logic                advance;
    logic                pulse;
    jtsm_result_t        res;
    logic                is_data;
    logic [IR_LEN_W-1:0] ir_bits;
    logic [CNT_W-1:0]    shift_len;
    logic [CNT_W-1:0]    cnt_inc;

    // Take a request whenever the result slot is free or being drained
    assign advance = q_valid && (!out_valid_reg || pop);
    assign q_pop   = advance;
    assign empty   = !out_valid_reg;
    assign result  = out_res_reg;

    // Clamp the instruction length to 1..32
    always_comb
    begin
        if (ir_length == '0)
        begin
            ir_bits = IR_LEN_W'(1);
        end
        else if (ir_length > IR_LEN_MAX)
        begin
            ir_bits = IR_LEN_MAX;
        end
        else
        begin
            ir_bits = ir_length;
        end
    end

    assign is_data   = (kind_reg == KIND_DATA);
    assign shift_len = is_data ? CNT_W'(DATA_BITS) : CNT_W'(ir_bits);
    assign cnt_inc   = cnt_reg + 1'b1;

    // Sequencer: start commands when idle, produce one pulse per tick of a running command
    always_comb
    begin
        phase_next    = phase_reg;
        kind_next     = kind_reg;
        tap_idle_next = tap_idle_reg;
        last_ir_next  = last_ir_reg;
        shift_next    = shift_reg;
        cap_next      = cap_reg;
        cnt_next      = cnt_reg;
        pulse         = 1'b0;
        res           = '0;

        if (advance && !q_item.is_tick && phase_reg == PH_IDLE)
        begin
            cnt_next   = '0;
            cap_next   = '0;
            shift_next = SHIFT_W'(q_item.word);
            unique case (q_item.kind)
                KIND_RESET:
                begin
                    kind_next  = KIND_RESET;
                    shift_next = '0;
                    phase_next = PH_RESET;
                end
                KIND_SETIR:
                begin
                    if (q_item.word != last_ir_reg)
                    begin
                        last_ir_next = q_item.word;
                        kind_next    = KIND_SETIR;
                        phase_next   = PH_MOVE;
                    end
                end
                KIND_DETIR:
                begin
                    kind_next  = KIND_DETIR;
                    phase_next = tap_idle_reg ? PH_MOVE : PH_RESET;
                end
                default:
                begin
                    kind_next  = KIND_DATA;
                    phase_next = PH_MOVE;
                end
            endcase
        end
        else if (advance && q_item.is_tick)
        begin
            unique case (phase_reg)
                PH_RESET:
                begin
                    // TMS 1,1,1,1,1,0
                    pulse    = 1'b1;
                    res.tms  = (cnt_reg < CNT_W'(5));
                    cnt_next = cnt_inc;
                    if (cnt_reg == CNT_W'(5))
                    begin
                        tap_idle_next = 1'b1;
                        cnt_next      = '0;
                        if (kind_reg == KIND_RESET)
                        begin
                            res.done   = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_MOVE;
                        end
                    end
                end
                PH_MOVE:
                begin
                    // TMS 1,0,0 to Shift-DR or 1,1,0,0 to Shift-IR
                    pulse    = 1'b1;
                    res.tms  = is_data ? (cnt_reg == '0) : (cnt_reg < CNT_W'(2));
                    cnt_next = cnt_inc;
                    if (cnt_reg == (is_data ? CNT_W'(2) : CNT_W'(3)))
                    begin
                        phase_next = PH_SHIFT;
                        cnt_next   = '0;
                    end
                end
                PH_SHIFT:
                begin
                    // Shift LSB first, capture TDO, raise TMS on the last bit
                    pulse      = 1'b1;
                    res.tdi    = shift_reg[0];
                    shift_next = shift_reg >> 1;
                    if (q_item.tdo && cnt_reg < CNT_W'(WORD_W))
                    begin
                        cap_next = cap_reg | (WORD_W'(1) << cnt_reg[4:0]);
                    end
                    res.tms  = (cnt_inc >= shift_len);
                    cnt_next = cnt_inc;
                    if (cnt_inc >= shift_len)
                    begin
                        phase_next = PH_EXIT;
                        cnt_next   = '0;
                    end
                end
                PH_EXIT:
                begin
                    // TMS 1,0 back to Run-Test/Idle
                    pulse    = 1'b1;
                    res.tms  = (cnt_reg == '0);
                    cnt_next = cnt_inc;
                    if (cnt_reg != '0)
                    begin
                        res.done   = 1'b1;
                        res.cap    = cap_reg;
                        phase_next = PH_IDLE;
                        cnt_next   = '0;
                    end
                end
                default:
                begin
                    // Tick while idle: drop
                    cnt_next = '0;
                end
            endcase
        end
    end

    // Load or drain the result slot
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (advance && pulse)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            kind_reg      <= KIND_RESET;
            tap_idle_reg  <= 1'b0;
            last_ir_reg   <= LAST_IR_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            tap_idle_reg  <= tap_idle_next;
            last_ir_reg   <= last_ir_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold shift data, capture word and result payload
    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        cap_reg     <= cap_next;
        out_res_reg <= out_res_next;
    end

endmodule

>>> rtl/core/jtag_tap_shift_master.sv
// Top level of the JTAG TAP shift master: front end, request queue, sequencer.
// Depends on jtsm_pkg, jtsm_front, jtsm_queue, jtsm_back.
//
//   channel    | handshake              | payload
//   -----------+------------------------+--------------------------------------------
//   request    | push / full            | operation, shift_word, tdo_sample
//   result     | empty / pop            | tms_level, tdi_level, sequence_done,
//              |                        | captured_word
//   config     | cfg_write              | cfg_data (ir_length)
//
// One request per clock is taken while the queue is not full; the sequencer
// retires one request per clock while the result slot is free or being drained.
// A tick that makes a pulse goes into the queue, then into the result register.
// A stalled result holds the sequencer; the two-entry queue keeps accepting
// until it fills. Reset clears the queue, the result slot and the TAP state
// (TAP state unknown, last instruction all ones, ir_length 5).
module jtag_tap_shift_master
    import jtsm_pkg::*;
#(
    parameter int DATA_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [2:0]          operation,
    input  logic [WORD_W-1:0]   shift_word,
    input  logic                tdo_sample,
    output logic                empty,
    input  logic                pop,
    output logic                tms_level,
    output logic                tdi_level,
    output logic                sequence_done,
    output logic [WORD_W-1:0]   captured_word,
    input  logic                cfg_write,
    input  logic [IR_LEN_W-1:0] cfg_data
);

    logic [IR_LEN_W-1:0] ir_length_reg;
    logic                keep;
    jtsm_item_t          fe_item;
    logic                q_valid;
    logic                q_pop;
    jtsm_item_t          q_item;
    jtsm_result_t        result;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_length_reg <= IR_LEN_RESET;
        end
        else if (cfg_write)
        begin
            ir_length_reg <= cfg_data;
        end
    end

    jtsm_front u_front (
        .operation  (operation),
        .shift_word (shift_word),
        .tdo_sample (tdo_sample),
        .keep       (keep),
        .item       (fe_item)
    );

    jtsm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push && keep),
        .wr_item  (fe_item),
        .full     (full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_item  (q_item)
    );

    jtsm_back #(
        .DATA_BITS (DATA_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ir_length (ir_length_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    assign tms_level     = result.tms;
    assign tdi_level     = result.tdi;
    assign sequence_done = result.done;
    assign captured_word = result.cap;

endmodule

>>> rtl/core/jtsm_checker.sv
// Port-level checks for the JTAG TAP shift master, bound to the top level.
// Depends on jtsm_pkg and jtag_tap_shift_master.
module jtsm_checker
    import jtsm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input logic                tms_level,
    input logic                tdi_level,
    input logic                sequence_done,
    input logic [WORD_W-1:0]   captured_word
);

    // Reset leaves the queue not full and no result pending
    a_reset_clear: assert property (@(posedge clk)
        !rst_n |=> (empty && !full))
        else $error("queue or result slot not cleared by reset");

    // Captured word only accompanies the final pulse
    a_cap_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !sequence_done) |-> (captured_word == '0))
        else $error("captured word on a pulse that is not the last");

    // The last pulse of every command returns TMS low with TDI low
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && sequence_done) |-> (!tms_level && !tdi_level))
        else $error("final pulse does not land in Run-Test/Idle");

    // A result not taken holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(tms_level) && $stable(tdi_level)
            && $stable(sequence_done) && $stable(captured_word)))
        else $error("pending result changed before pop");

endmodule

bind jtag_tap_shift_master jtsm_checker u_jtsm_checker (.*);
